// ----- rtl/core/keepalive_latency_tracker_top_assert.svh -----
// assertion macros for the keepalive latency tracker checker
// needs clk and rst_n in the scope where a macro is used
`ifndef KEEPALIVE_LATENCY_TRACKER_TOP_ASSERT_SVH
`define KEEPALIVE_LATENCY_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define KLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keepalive tracker check failed");

// next-cycle implication
`define KLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keepalive tracker check failed");

`endif

// ----- rtl/core/klt_pkg.sv -----
// shared codes, control word layout and microcode rom of the keepalive tracker
// no dependencies
package klt_pkg;

  localparam int unsigned UAW       = 4;
  localparam int unsigned WORD_BITS = 32;

  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_POLL  = 2'd2;
  localparam logic [1:0] OP_REPLY = 2'd3;

  localparam logic [2:0] ST_SENT    = 3'd0;
  localparam logic [2:0] ST_MATCH   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_RESET   = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  localparam logic [31:0] DEFAULT_INTERVAL = 32'd120000;

  // datapath actions
  localparam logic [3:0] A_NOP        = 4'd0;
  localparam logic [3:0] A_LOAD       = 4'd1;
  localparam logic [3:0] A_CLEAR      = 4'd2;
  localparam logic [3:0] A_FREE_STEP  = 4'd3;
  localparam logic [3:0] A_AGE_STEP   = 4'd4;
  localparam logic [3:0] A_WRITE      = 4'd5;
  localparam logic [3:0] A_MATCH_STEP = 4'd6;
  localparam logic [3:0] A_TAKE       = 4'd7;
  localparam logic [3:0] A_DIV_STEP   = 4'd8;
  localparam logic [3:0] A_MEAN       = 4'd9;

  // jump conditions
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_DISPATCH = 3'd2;
  localparam logic [2:0] C_FREE     = 3'd3;
  localparam logic [2:0] C_MATCH    = 3'd4;
  localparam logic [2:0] C_NOT_DUE  = 3'd5;
  localparam logic [2:0] C_CNT_WRAP = 3'd6;

  // loop lengths
  localparam logic L_TABLE = 1'b0;
  localparam logic L_WORD  = 1'b1;

  // micro addresses
  localparam logic [UAW-1:0] U_IDLE    = 4'd0;
  localparam logic [UAW-1:0] U_RST     = 4'd1;
  localparam logic [UAW-1:0] U_POLL    = 4'd2;
  localparam logic [UAW-1:0] U_SEND    = 4'd3;
  localparam logic [UAW-1:0] U_OLDEST  = 4'd4;
  localparam logic [UAW-1:0] U_WRITE   = 4'd5;
  localparam logic [UAW-1:0] U_REPLY   = 4'd6;
  localparam logic [UAW-1:0] U_UNKNOWN = 4'd7;
  localparam logic [UAW-1:0] U_TAKE    = 4'd8;
  localparam logic [UAW-1:0] U_DIV     = 4'd9;
  localparam logic [UAW-1:0] U_MEAN    = 4'd10;
  localparam logic [UAW-1:0] U_MATCHED = 4'd11;
  localparam logic [UAW-1:0] U_NONE    = 4'd12;

  typedef struct packed {
    logic [3:0]     act;
    logic [2:0]     cond;
    logic [UAW-1:0] target;
    logic           loop;
    logic           len;
    logic           emit;
    logic [2:0]     status;
  } ctrl_t;

  typedef struct packed {
    logic free;
    logic match;
    logic due;
    logic cnt_wrap;
  } flags_t;

  function automatic ctrl_t ucode(input logic [UAW-1:0] addr);
    ctrl_t cw;
    cw = '{act: A_NOP, cond: C_ALWAYS, target: U_IDLE, loop: 1'b0, len: L_TABLE,
           emit: 1'b0, status: ST_NONE};
    case (addr)
      U_IDLE: begin
        cw.act  = A_LOAD;
        cw.cond = C_DISPATCH;
      end
      U_RST: begin
        cw.act    = A_CLEAR;
        cw.emit   = 1'b1;
        cw.status = ST_RESET;
      end
      U_POLL: begin
        cw.cond   = C_NOT_DUE;
        cw.target = U_NONE;
      end
      U_SEND: begin
        cw.act    = A_FREE_STEP;
        cw.cond   = C_FREE;
        cw.target = U_WRITE;
        cw.loop   = 1'b1;
      end
      U_OLDEST: begin
        cw.act  = A_AGE_STEP;
        cw.cond = C_NEVER;
        cw.loop = 1'b1;
      end
      U_WRITE: begin
        cw.act    = A_WRITE;
        cw.emit   = 1'b1;
        cw.status = ST_SENT;
      end
      U_REPLY: begin
        cw.act    = A_MATCH_STEP;
        cw.cond   = C_MATCH;
        cw.target = U_TAKE;
        cw.loop   = 1'b1;
      end
      U_UNKNOWN: begin
        cw.emit   = 1'b1;
        cw.status = ST_UNKNOWN;
      end
      U_TAKE: begin
        cw.act    = A_TAKE;
        cw.cond   = C_CNT_WRAP;
        cw.target = U_MATCHED;
      end
      U_DIV: begin
        cw.act  = A_DIV_STEP;
        cw.cond = C_NEVER;
        cw.loop = 1'b1;
        cw.len  = L_WORD;
      end
      U_MEAN: begin
        cw.act    = A_MEAN;
        cw.emit   = 1'b1;
        cw.status = ST_MATCH;
      end
      U_MATCHED: begin
        cw.emit   = 1'b1;
        cw.status = ST_MATCH;
      end
      U_NONE: begin
        cw.emit   = 1'b1;
        cw.status = ST_NONE;
      end
      default: begin
        cw.act = A_NOP;
      end
    endcase
    return cw;
  endfunction

  function automatic logic [UAW-1:0] dispatch(input logic [1:0] op);
    logic [UAW-1:0] addr;
    case (op)
      OP_RESET: addr = U_RST;
      OP_SEND:  addr = U_SEND;
      OP_POLL:  addr = U_POLL;
      OP_REPLY: addr = U_REPLY;
      default:  addr = U_IDLE;
    endcase
    return addr;
  endfunction

endpackage

// ----- rtl/core/klt_sequencer.sv -----
// microcode sequencer: step counter, loop counter and conditional jumps
// depends on klt_pkg
module klt_sequencer #(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    operation,
  input  klt_pkg::flags_t               flags,
  output klt_pkg::ctrl_t                ctrl,
  output logic [((PENDING_DEPTH > 16) ? $clog2(PENDING_DEPTH) : 5)-1:0] cnt,
  output logic                          busy
);
  import klt_pkg::*;

  localparam int unsigned CW = (PENDING_DEPTH > 16) ? $clog2(PENDING_DEPTH) : 5;

  logic [UAW-1:0] pc_r, pc_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           cond_hit;
  logic           cnt_last;

  assign ctrl = ucode(pc_r);
  assign cnt  = cnt_r;
  assign busy = (pc_r != U_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_DISPATCH: cond_hit = start;
      C_FREE:     cond_hit = flags.free;
      C_MATCH:    cond_hit = flags.match;
      C_NOT_DUE:  cond_hit = !flags.due;
      C_CNT_WRAP: cond_hit = flags.cnt_wrap;
      default:    cond_hit = 1'b0;
    endcase
  end

  assign cnt_last = (ctrl.len == L_WORD) ? (cnt_r == CW'(WORD_BITS - 1))
                                         : (cnt_r == CW'(PENDING_DEPTH - 1));

  always_comb begin
    if (cond_hit) begin
      pc_nxt = (ctrl.cond == C_DISPATCH) ? dispatch(operation) : ctrl.target;
    end else if (ctrl.cond == C_DISPATCH) begin
      pc_nxt = pc_r;
    end else if (ctrl.loop && !cnt_last) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
    if (pc_nxt != pc_r || pc_r == U_IDLE) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= U_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/keepalive_latency_tracker_top.sv -----
// keepalive latency tracker: pending probe table, counters and serial mean update
// depends on klt_pkg and klt_sequencer
//
// usage: drive in_operation, in_now_ms and in_reply_id with start high; the word
// is taken on an edge where start is high and busy is low. busy then stays high
// until the result, which shows on the out_ ports for one cycle with out_strobe.
// out_last_ping, out_average_ping, out_sent_count and out_received_count show
// the state after the operation and hold it while idle.
// the table scans walk one entry a cycle and the mean update runs a restoring
// divider one quotient bit a cycle; one word is in work at a time.
// reset (rst_n low) empties the table, clears all counters and loads the
// interval register with 120000; cfg_wr_en writes the interval. The user
// must write it only while idle; the block itself does not enforce it.
// the receiver cannot stall: a result is gone after its strobe cycle.
module keepalive_latency_tracker_top #(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_now_ms,
  input  logic [31:0]        in_reply_id,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output logic [31:0]        out_probe_id,
  output logic signed [31:0] out_last_ping,
  output logic signed [31:0] out_average_ping,
  output logic [31:0]        out_sent_count,
  output logic [31:0]        out_received_count
);
  import klt_pkg::*;

  localparam int unsigned CW = (PENDING_DEPTH > 16) ? $clog2(PENDING_DEPTH) : 5;
  localparam int unsigned IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  ctrl_t          ctrl;
  flags_t         flags;
  logic [CW-1:0]  cnt;

  logic [31:0]              pend_id_r   [PENDING_DEPTH];
  logic [31:0]              pend_time_r [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] pend_valid_r;

  logic [31:0]   interval_r;
  logic [IW-1:0] write_slot_r;
  logic [31:0]   next_id_r;
  logic [31:0]   last_send_r;
  logic [31:0]   ping_last_r;
  logic [31:0]   ping_mean_r;
  logic [31:0]   reply_count_r;

  logic [31:0]   now_r;
  logic [31:0]   rid_r;
  logic [IW-1:0] slot_r;
  logic [31:0]   best_r;
  logic [31:0]   rem_r;
  logic [31:0]   quo_r;
  logic [31:0]   div_r;
  logic          neg_r;

  logic          strobe_r;
  logic [2:0]    status_r;
  logic [31:0]   probe_r;

  logic [IW-1:0] cnt_idx;
  logic [IW:0]   scan_sum;
  logic [IW-1:0] scan_idx;
  logic [31:0]   new_id;
  logic [31:0]   age;
  logic [31:0]   ping_nxt;
  logic [32:0]   diff;
  logic [32:0]   mag;
  logic [32:0]   rem_sh;
  logic [32:0]   rem_sub;
  logic [IW-1:0] slot_inc;

  klt_sequencer #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .operation(in_operation),
    .flags    (flags),
    .ctrl     (ctrl),
    .cnt      (cnt),
    .busy     (busy)
  );

  assign cnt_idx  = cnt[IW-1:0];
  assign scan_sum = {1'b0, write_slot_r} + {1'b0, cnt_idx};
  assign scan_idx = (scan_sum >= (IW+1)'(PENDING_DEPTH))
                    ? IW'(scan_sum - (IW+1)'(PENDING_DEPTH)) : scan_sum[IW-1:0];
  assign new_id   = next_id_r + 32'd1;
  assign age      = new_id - pend_id_r[cnt_idx];
  assign ping_nxt = now_r - pend_time_r[slot_r];
  assign diff     = {ping_nxt[31], ping_nxt} - {ping_mean_r[31], ping_mean_r};
  assign mag      = diff[32] ? (33'd0 - diff) : diff;
  assign rem_sh   = {rem_r, quo_r[31]};
  assign rem_sub  = rem_sh - {1'b0, div_r};
  assign slot_inc = (slot_r == IW'(PENDING_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  assign flags.free     = !pend_valid_r[scan_idx];
  assign flags.match    = pend_valid_r[cnt_idx] && (pend_id_r[cnt_idx] == rid_r);
  assign flags.due      = (now_r - last_send_r) > interval_r;
  assign flags.cnt_wrap = &reply_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r    <= DEFAULT_INTERVAL;
      pend_valid_r  <= '0;
      write_slot_r  <= '0;
      next_id_r     <= '0;
      last_send_r   <= '0;
      ping_last_r   <= '0;
      ping_mean_r   <= '0;
      reply_count_r <= '0;
      strobe_r      <= 1'b0;
      status_r      <= ST_NONE;
      probe_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      strobe_r <= ctrl.emit;
      if (ctrl.emit) begin
        status_r <= ctrl.status;
        probe_r  <= (ctrl.status == ST_SENT) ? new_id : '0;
      end
      case (ctrl.act)
        A_LOAD: begin
          if (start) begin
            now_r  <= in_now_ms;
            rid_r  <= in_reply_id;
            slot_r <= '0;
            best_r <= '0;
          end
        end
        A_CLEAR: begin
          pend_valid_r  <= '0;
          write_slot_r  <= '0;
          next_id_r     <= '0;
          ping_last_r   <= '0;
          ping_mean_r   <= '0;
          reply_count_r <= '0;
          last_send_r   <= now_r;
        end
        A_FREE_STEP: begin
          if (flags.free) begin
            slot_r <= scan_idx;
          end
        end
        A_AGE_STEP: begin
          if (age > best_r) begin
            best_r <= age;
            slot_r <= cnt_idx;
          end
        end
        A_WRITE: begin
          pend_id_r[slot_r]    <= new_id;
          pend_time_r[slot_r]  <= now_r;
          pend_valid_r[slot_r] <= 1'b1;
          write_slot_r         <= slot_inc;
          next_id_r            <= new_id;
          last_send_r          <= now_r;
        end
        A_MATCH_STEP: begin
          if (flags.match) begin
            slot_r <= cnt_idx;
          end
        end
        A_TAKE: begin
          pend_valid_r[slot_r] <= 1'b0;
          ping_last_r          <= ping_nxt;
          reply_count_r        <= reply_count_r + 32'd1;
          div_r                <= reply_count_r + 32'd1;
          neg_r                <= diff[32];
          quo_r                <= mag[31:0];
          rem_r                <= '0;
        end
        A_DIV_STEP: begin
          if (!rem_sub[32]) begin
            rem_r <= rem_sub[31:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh[31:0];
            quo_r <= {quo_r[30:0], 1'b0};
          end
        end
        A_MEAN: begin
          ping_mean_r <= ping_mean_r + (neg_r ? (32'd0 - quo_r) : quo_r);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_probe_id       = probe_r;
  assign out_last_ping      = $signed(ping_last_r);
  assign out_average_ping   = $signed(ping_mean_r);
  assign out_sent_count     = next_id_r;
  assign out_received_count = reply_count_r;

endmodule

// ----- rtl/core/klt_checker.sv -----
// port-level checks on the keepalive latency tracker, bound to the top level
// depends on klt_pkg and keepalive_latency_tracker_top_assert.svh
`include "keepalive_latency_tracker_top_assert.svh"

module klt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic [2:0]         out_status,
  input logic [31:0]        out_probe_id,
  input logic signed [31:0] out_last_ping,
  input logic [31:0]        out_sent_count,
  input logic [31:0]        out_received_count
);
  import klt_pkg::*;

  `KLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `KLT_ASSERT_NOW(a_done_strobe, $fell(busy), out_strobe)
  `KLT_ASSERT_NOW(a_probe_zero, out_strobe && out_status != ST_SENT, out_probe_id == 32'd0)
  `KLT_ASSERT_NOW(a_reset_clears, out_strobe && out_status == ST_RESET, out_sent_count == 32'd0 && out_received_count == 32'd0 && out_last_ping == 32'sd0)

endmodule

bind keepalive_latency_tracker_top klt_checker u_klt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_probe_id      (out_probe_id),
  .out_last_ping     (out_last_ping),
  .out_sent_count    (out_sent_count),
  .out_received_count(out_received_count)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench for keepalive_latency_tracker_top: directed and random command words
// checked against an in-bench prediction of the probe table, counters and mean
// depends on klt_pkg and keepalive_latency_tracker_top
module testbench;
  import klt_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [2:0]         status;
    logic [31:0]        probe_id;
    logic signed [31:0] last_ping;
    logic signed [31:0] average_ping;
    logic [31:0]        sent_count;
    logic [31:0]        received_count;
  } tracker_word_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_operation;
  logic [31:0]        in_now_ms;
  logic [31:0]        in_reply_id;
  logic               cfg_wr_en;
  logic [31:0]        cfg_wr_data;
  logic               out_strobe;
  logic [2:0]         out_status;
  logic [31:0]        out_probe_id;
  logic signed [31:0] out_last_ping;
  logic signed [31:0] out_average_ping;
  logic [31:0]        out_sent_count;
  logic [31:0]        out_received_count;

  // predicted tracker state
  logic [31:0]        m_interval;
  logic [31:0]        m_ids [DEPTH];
  logic [31:0]        m_times [DEPTH];
  logic               m_valid [DEPTH];
  int                 m_wslot;
  logic [31:0]        m_next_id;
  logic [31:0]        m_last_send;
  logic signed [31:0] m_ping_last;
  logic signed [31:0] m_mean;
  logic [31:0]        m_rcount;

  tracker_word_t expected_words[$];
  int            errors = 0;
  int            cycles = 0;
  int            gap_max = 17;
  logic [31:0]   clock_ms = 32'd0;
  int            n_words = 0;
  int            n_settings = 0;
  int            n_status [5];

  keepalive_latency_tracker_top #(
    .PENDING_DEPTH(DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_now_ms         (in_now_ms),
    .in_reply_id       (in_reply_id),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_probe_id      (out_probe_id),
    .out_last_ping     (out_last_ping),
    .out_average_ping  (out_average_ping),
    .out_sent_count    (out_sent_count),
    .out_received_count(out_received_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] issue_probe(input logic [31:0] now);
    logic [31:0] id;
    logic [31:0] age;
    logic [31:0] best_age;
    int          slot;
    int          s;
    id   = m_next_id + 32'd1;
    slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      s = (m_wslot + i) % DEPTH;
      if (slot < 0 && !m_valid[s]) slot = s;
    end
    if (slot < 0) begin
      // table full: overwrite the oldest probe
      best_age = 32'd0;
      slot     = 0;
      for (int i = 0; i < DEPTH; i++) begin
        age = id - m_ids[i];
        if (age > best_age) begin
          best_age = age;
          slot     = i;
        end
      end
    end
    m_ids[slot]   = id;
    m_times[slot] = now;
    m_valid[slot] = 1'b1;
    m_wslot       = (slot + 1) % DEPTH;
    m_next_id     = id;
    m_last_send   = now;
    return id;
  endfunction

  function automatic tracker_word_t track_word(input logic [1:0] op, input logic [31:0] now,
                                               input logic [31:0] rid);
    tracker_word_t w;
    logic [31:0]   elapsed;
    int            hit;
    longint        diff;
    longint        q;
    w.status   = ST_NONE;
    w.probe_id = 32'd0;
    case (op)
      OP_RESET: begin
        for (int i = 0; i < DEPTH; i++) m_valid[i] = 1'b0;
        m_wslot     = 0;
        m_next_id   = 32'd0;
        m_ping_last = 32'sd0;
        m_mean      = 32'sd0;
        m_rcount    = 32'd0;
        m_last_send = now;
        w.status    = ST_RESET;
      end
      OP_SEND: begin
        w.probe_id = issue_probe(now);
        w.status   = ST_SENT;
      end
      OP_POLL: begin
        elapsed = now - m_last_send;
        if (elapsed > m_interval) begin
          w.probe_id = issue_probe(now);
          w.status   = ST_SENT;
        end
      end
      default: begin
        hit = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (hit < 0 && m_valid[i] && m_ids[i] == rid) hit = i;
        end
        if (hit >= 0) begin
          m_valid[hit] = 1'b0;
          m_ping_last  = now - m_times[hit];
          m_rcount     = m_rcount + 32'd1;
          if (m_rcount != 32'd0) begin
            diff   = longint'(m_ping_last) - longint'(m_mean);
            q      = diff / longint'(m_rcount);
            m_mean = 32'(longint'(m_mean) + q);
          end
          w.status = ST_MATCH;
        end else begin
          w.status = ST_UNKNOWN;
        end
      end
    endcase
    w.last_ping      = m_ping_last;
    w.average_ping   = m_mean;
    w.sent_count     = m_next_id;
    w.received_count = m_rcount;
    return w;
  endfunction

  always @(posedge clk) begin : check_results
    tracker_word_t w;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        $error("result with status %0d arrived with no word pending", out_status);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_status);
          errors++;
        end
        if (out_probe_id !== w.probe_id) begin
          $error("probe_id: expected %0d, got %0d", w.probe_id, out_probe_id);
          errors++;
        end
        if (out_last_ping !== w.last_ping) begin
          $error("last_ping: expected %0d, got %0d", w.last_ping, out_last_ping);
          errors++;
        end
        if (out_average_ping !== w.average_ping) begin
          $error("average_ping: expected %0d, got %0d", w.average_ping, out_average_ping);
          errors++;
        end
        if (out_sent_count !== w.sent_count) begin
          $error("sent_count: expected %0d, got %0d", w.sent_count, out_sent_count);
          errors++;
        end
        if (out_received_count !== w.received_count) begin
          $error("received_count: expected %0d, got %0d", w.received_count,
                 out_received_count);
          errors++;
        end
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [31:0] now,
                           input logic [31:0] rid);
    int            gap;
    tracker_word_t w;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_now_ms    <= now;
    in_reply_id  <= rid;
    while (busy) @(negedge clk);
    @(posedge clk);
    w = track_word(op, now, rid);
    expected_words.push_back(w);
    n_status[w.status]++;
    n_words++;
  endtask

  // hold off until every pending result is back and the block is idle
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_interval(input logic [31:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    m_interval = value;
    n_settings++;
  endtask

  task automatic test_reset_word();
    send_word(OP_RESET, 32'd0, 32'd0);
    send_word(OP_RESET, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_REPLY, 32'd10, 32'd0);
    send_word(OP_REPLY, 32'd20, 32'hffff_ffff);
    send_word(OP_POLL, 32'hffff_ffff, 32'd0);
  endtask

  // negative, most negative and most positive round trips, duplicate reply
  task automatic test_round_trip();
    send_word(OP_RESET, 32'd0, 32'd0);
    send_word(OP_SEND, 32'd100, 32'd0);
    send_word(OP_SEND, 32'hffff_ffff, 32'd0);
    send_word(OP_REPLY, 32'd50, 32'd1);
    send_word(OP_REPLY, 32'h7fff_ffff, 32'd2);
    send_word(OP_REPLY, 32'h8000_0000, 32'd2);
    send_word(OP_SEND, 32'h8000_0000, 32'd0);
    send_word(OP_REPLY, 32'hffff_ffff, 32'd3);
  endtask

  task automatic test_poll_timing();
    send_word(OP_RESET, 32'd1000, 32'd0);
    send_word(OP_POLL, 32'd1000 + DEFAULT_INTERVAL, 32'd0);
    send_word(OP_POLL, 32'd1001 + DEFAULT_INTERVAL, 32'd0);
    send_word(OP_RESET, 32'hffff_ff00, 32'd0);
    send_word(OP_POLL, 32'hffff_ff01 + DEFAULT_INTERVAL, 32'd0);
  endtask

  task automatic test_interval_extremes();
    set_interval(32'd0);
    send_word(OP_RESET, 32'd5, 32'd0);
    send_word(OP_POLL, 32'd5, 32'd0);
    send_word(OP_POLL, 32'd6, 32'd0);
    set_interval(32'hffff_ffff);
    send_word(OP_POLL, 32'd5, 32'd0);
    send_word(OP_POLL, 32'd4, 32'd0);
  endtask

  // overfill the table, then answer evicted and live probes
  task automatic test_table_overflow();
    set_interval(DEFAULT_INTERVAL);
    clock_ms = $urandom;
    send_word(OP_RESET, clock_ms, 32'd0);
    for (int i = 0; i < 3 * DEPTH; i++) begin
      clock_ms += $urandom_range(0, 500);
      send_word(OP_SEND, clock_ms, 32'd0);
    end
    for (int i = 0; i < 12; i++) begin
      clock_ms += $urandom_range(0, 500);
      send_word(OP_REPLY, clock_ms, 32'($urandom_range(1, 3 * DEPTH)));
    end
    for (int i = 0; i < 8; i++) begin
      clock_ms += $urandom_range(0, 500);
      send_word(OP_SEND, clock_ms, 32'd0);
    end
  endtask

  task automatic test_random_sessions(input int count, input logic [31:0] step_max);
    int          r;
    int          live[$];
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] rid;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 90) clock_ms += $urandom_range(0, step_max);
      now = clock_ms;
      rid = $urandom;
      if (r < 3) begin
        op = OP_RESET;
      end else if (r < 30) begin
        op = OP_SEND;
      end else if (r < 55) begin
        op = OP_POLL;
      end else if (r < 85) begin
        op = OP_REPLY;
        live.delete();
        for (int i = 0; i < DEPTH; i++) if (m_valid[i]) live.push_back(i);
        if (live.size() > 0) rid = m_ids[live[$urandom_range(0, live.size() - 1)]];
      end else if (r < 92) begin
        // stale or recent id, live or not
        op  = OP_REPLY;
        rid = m_next_id - 32'($urandom_range(0, 40));
      end else begin
        op  = 2'($urandom_range(0, 3));
        now = $urandom;
        if ($urandom_range(0, 1) == 1) clock_ms = now;
      end
      send_word(op, now, rid);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_RESET;
    in_now_ms    = 32'd0;
    in_reply_id  = 32'd0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 32'd0;
    m_interval   = DEFAULT_INTERVAL;
    for (int i = 0; i < DEPTH; i++) begin
      m_ids[i]   = 32'd0;
      m_times[i] = 32'd0;
      m_valid[i] = 1'b0;
    end
    m_wslot     = 0;
    m_next_id   = 32'd0;
    m_last_send = 32'd0;
    m_ping_last = 32'sd0;
    m_mean      = 32'sd0;
    m_rcount    = 32'd0;
    for (int i = 0; i < 5; i++) n_status[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_word();
    test_round_trip();
    test_poll_timing();
    test_interval_extremes();
    test_table_overflow();

    set_interval(DEFAULT_INTERVAL);
    test_random_sessions(280, 60000);
    gap_max = 0;
    set_interval(32'd0);
    test_random_sessions(250, 3);
    gap_max = 17;
    set_interval(32'($urandom_range(1, 500)));
    test_random_sessions(280, 400);
    set_interval(32'hffff_ffff);
    test_random_sessions(250, 32'hffff_ffff);
    gap_max = 0;
    set_interval($urandom);
    test_random_sessions(250, 32'hffff_ffff);
    gap_max = 17;
    set_interval(32'd1000);
    test_random_sessions(280, 1500);

    wait_idle();
    repeat (60) @(posedge clk);
    $display("%0d words over %0d interval settings: %0d resets, %0d probes sent,",
             n_words, n_settings, n_status[ST_RESET], n_status[ST_SENT]);
    $display("%0d replies matched, %0d unknown replies, %0d polls with nothing due",
             n_status[ST_MATCH], n_status[ST_UNKNOWN], n_status[ST_NONE]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
